// File: sv/hnm_pkg.sv
// Shared types, constants and helper functions of the height map to normal map block.
// Depends on nothing; every other file of the block imports it.
package hnm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int DIM_W   = 12;
    localparam int GAIN_W  = 24;
    localparam int HS_W    = 16;
    localparam int POS_W   = 11;
    localparam int NRM_W   = 16;
    localparam int NY_W    = 15;
    localparam int LANES   = 4;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CCNT_W  = $clog2(MAX_WIDTH + 4);
    localparam int RCNT_W  = $clog2(MAX_HEIGHT + 4);

    // Stencil sum and its magnitude: nine full-scale samples at most.
    localparam int D_W     = HS_W + 5;
    localparam int MAG_W   = HS_W + 4;
    localparam int SX_W    = MAG_W + GAIN_W - 16;
    localparam int ACC_W   = 2 * SX_W;
    localparam int RAD_W   = 2 * ((ACC_W + 3) / 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int Q_W     = 15;
    localparam int DIV_W   = ROOT_W + Q_W - 1;
    localparam int CNT_W   = 5;

    localparam int ONE_Q14 = 16384;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SLOPE_GAIN   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

    typedef struct packed {
        logic                  interior;
        logic                  frame_end;
        logic [POS_W-1:0]      col;
        logic [POS_W-1:0]      row;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dz;
    } t_job;

    function automatic logic [CCNT_W-1:0] eff_width(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return CCNT_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return CCNT_W'(MAX_WIDTH);
        end else begin
            return CCNT_W'(v);
        end
    endfunction

    function automatic logic [RCNT_W-1:0] eff_height(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return RCNT_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            return RCNT_W'(MAX_HEIGHT);
        end else begin
            return RCNT_W'(v);
        end
    endfunction

endpackage

// File: sv/hnm_front.sv
// Front part: raster counters, four-row line store and the two stencil sums.
// Depends on hnm_pkg; feeds the job queue.
module hnm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hnm_pkg::t_dims              i_dims,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [hnm_pkg::HS_W-1:0]    i_height_sample,
    input  logic [hnm_pkg::Q_LVL_W-1:0] i_q_level,
    output logic                        o_push,
    output hnm_pkg::t_job               o_job
);
    import hnm_pkg::*;

    logic [CCNT_W-1:0] r_col, n_col, col0, w_eff;
    logic [RCNT_W-1:0] r_row, n_row, row0, h_eff, orow;
    logic [COL_W-1:0]  ic, ahead;
    logic [HS_W-1:0]   sample;
    logic              w_take, produce, interior, end_px;

    wire [LANES-1:0][HS_W-1:0] w_rd_v;
    wire [LANES-1:0][HS_W-1:0] w_rd_a;

    logic              r_s1_vld, r_s1_prod, r_s1_int, r_s1_end;
    logic [1:0]        r_s1_lane;
    logic [POS_W-1:0]  r_s1_col, r_s1_row;
    logic [HS_W-1:0]   r_s1_sample;
    logic [HS_W-1:0]   r_h1, r_h2, r_p1;
    logic [HS_W-1:0]   center, ahead_v;

    function automatic logic signed [D_W-1:0] stencil(input logic [HS_W-1:0] a,
        input logic [HS_W-1:0] b, input logic [HS_W-1:0] c, input logic [HS_W-1:0] e);
        logic signed [D_W-1:0] sa, sb, sc, se;
        sa = $signed({{(D_W-HS_W){1'b0}}, a});
        sb = $signed({{(D_W-HS_W-3){1'b0}}, b, 3'b000});
        sc = $signed({{(D_W-HS_W-3){1'b0}}, c, 3'b000});
        se = $signed({{(D_W-HS_W){1'b0}}, e});
        return se - sa + sb - sc;
    endfunction

    assign o_in_stall = ({1'b0, i_q_level} + (Q_LVL_W+1)'(r_s1_vld)) >= (Q_LVL_W+1)'(Q_DEPTH);
    assign w_take     = i_in_valid && !o_in_stall;

    always_comb begin
        w_eff = eff_width(i_dims.width);
        h_eff = eff_height(i_dims.height);
        col0  = r_col;
        row0  = r_row;
        if (col0 >= w_eff) begin
            col0 = '0;
            row0 = row0 + RCNT_W'(1);
        end
        if (row0 >= h_eff + RCNT_W'(2)) begin
            row0 = '0;
        end
        ic       = col0[COL_W-1:0];
        ahead    = ic + COL_W'(2);
        orow     = row0 - RCNT_W'(2);
        sample   = (!i_cmd && row0 < h_eff) ? i_height_sample : '0;
        produce  = row0 >= RCNT_W'(2);
        interior = row0 >= RCNT_W'(4) && row0 < h_eff &&
                   col0 >= CCNT_W'(2) && col0 + CCNT_W'(3) <= w_eff;
        end_px   = produce && row0 == h_eff + RCNT_W'(1) && col0 == w_eff - CCNT_W'(1);
        if (end_px) begin
            n_col = '0;
            n_row = '0;
        end else if (col0 + CCNT_W'(1) >= w_eff) begin
            n_col = '0;
            n_row = row0 + RCNT_W'(1);
        end else begin
            n_col = col0 + CCNT_W'(1);
            n_row = row0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_take;
            if (w_take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Each lane holds one row of the last four; read old data before the write.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [HS_W-1:0] r_mem [MAX_WIDTH];
        logic [HS_W-1:0] r_rd_v, r_rd_a;
        always_ff @(posedge i_clk) begin
            if (w_take) begin
                if (row0[1:0] == 2'(g)) begin
                    r_mem[ic] <= sample;
                end
                r_rd_v <= r_mem[ic];
                r_rd_a <= r_mem[ahead];
            end
        end
        assign w_rd_v[g] = r_rd_v;
        assign w_rd_a[g] = r_rd_a;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_lane   <= row0[1:0];
            r_s1_col    <= POS_W'(ic);
            r_s1_row    <= POS_W'(orow);
            r_s1_prod   <= produce;
            r_s1_int    <= interior;
            r_s1_end    <= end_px;
            r_s1_sample <= sample;
        end
        if (r_s1_vld) begin
            r_h2 <= r_h1;
            r_h1 <= center;
            r_p1 <= ahead_v;
        end
    end

    always_comb begin
        center          = w_rd_v[r_s1_lane + 2'd2];
        ahead_v         = w_rd_a[r_s1_lane + 2'd2];
        o_push          = r_s1_vld && r_s1_prod;
        o_job.interior  = r_s1_int;
        o_job.frame_end = r_s1_end;
        o_job.col       = r_s1_col;
        o_job.row       = r_s1_row;
        o_job.dx        = stencil(r_h2, r_h1, r_p1, ahead_v);
        o_job.dz        = stencil(w_rd_v[r_s1_lane], w_rd_v[r_s1_lane + 2'd1],
                                  w_rd_v[r_s1_lane + 2'd3], r_s1_sample);
    end

endmodule

// File: sv/hnm_queue.sv
// Short job queue between the front and the normal unit.
// Depends on hnm_pkg for the job record and the depth.
module hnm_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  hnm_pkg::t_job               i_job,
    input  logic                        i_pop,
    output hnm_pkg::t_job               o_job,
    output logic [hnm_pkg::Q_LVL_W-1:0] o_level
);
    import hnm_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + Q_LVL_W'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - Q_LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd];
    assign o_level = r_level;

endmodule

// File: sv/hnm_back.sv
// Normal unit: slope scaling, squares, integer square root and division, one bit a cycle.
// Depends on hnm_pkg; owns the output register of the result channel.
module hnm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [hnm_pkg::GAIN_W-1:0]        i_gain,
    input  logic                              i_avail,
    input  hnm_pkg::t_job                     i_job,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [hnm_pkg::NRM_W-1:0]  o_normal_x,
    output logic [hnm_pkg::NY_W-1:0]          o_normal_y,
    output logic signed [hnm_pkg::NRM_W-1:0]  o_normal_z,
    output logic [hnm_pkg::POS_W-1:0]         o_pixel_column,
    output logic [hnm_pkg::POS_W-1:0]         o_pixel_row,
    output logic                              o_frame_end
);
    import hnm_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_last, w_load;

    logic               r_sgx, r_sgz, r_end;
    logic [POS_W-1:0]   r_col, r_row;
    logic [ACC_W-1:0]   r_mx, r_mz, r_accx, r_accz, n_accx, n_accz, rndx, rndz;
    logic [SX_W-1:0]    r_bx, r_bz, r_sx, r_sz;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [REM_W-1:0]   r_rem, n_rem, rem_t, trial;
    logic [DIV_W-1:0]   r_dv, r_rx, r_rz, r_ry;
    logic [Q_W-1:0]     r_qx, r_qz, r_qy;
    logic               gex, gez, gey, ge_root;
    logic [D_W-1:0]     absx, absz;

    logic               r_out_vld, r_oend;
    logic [NRM_W-1:0]   r_onx, r_onz;
    logic [NY_W-1:0]    r_ony;
    logic [POS_W-1:0]   r_ocol, r_orow;

    function automatic logic [Q_W-1:0] clamp_q(input logic [Q_W-1:0] q);
        return (q > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q;
    endfunction

    function automatic logic [NRM_W-1:0] signed_q(input logic s, input logic [Q_W-1:0] q);
        logic [NRM_W-1:0] m;
        m = NRM_W'(clamp_q(q));
        return s ? -m : m;
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    n_state = i_job.interior ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:  if (w_last) n_state = ST_SQR;
            ST_SQR:  if (w_last) n_state = ST_ROOT;
            ST_ROOT: if (w_last) n_state = ST_DIV;
            ST_DIV:  if (w_last) n_state = ST_DONE;
            ST_DONE: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        w_last = 1'b0;
        case (r_state)
            ST_IDLE: o_pop  = i_avail;
            ST_MUL:  w_last = r_cnt == CNT_W'(GAIN_W - 1);
            ST_SQR:  w_last = r_cnt == CNT_W'(SX_W - 1);
            ST_ROOT: w_last = r_cnt == CNT_W'(ROOT_W - 1);
            ST_DIV:  w_last = r_cnt == CNT_W'(Q_W - 1);
            ST_DONE: w_load = !r_out_vld || !i_out_stall;
            default: ;
        endcase
    end

    always_comb begin
        absx    = i_job.dx[D_W-1] ? D_W'(-i_job.dx) : D_W'(i_job.dx);
        absz    = i_job.dz[D_W-1] ? D_W'(-i_job.dz) : D_W'(i_job.dz);
        n_accx  = r_accx + (r_bx[0] ? r_mx : '0);
        n_accz  = r_accz + (r_bz[0] ? r_mz : '0);
        rndx    = n_accx + ACC_W'(32768);
        rndz    = n_accz + ACC_W'(32768);
        rem_t   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial   = REM_W'({r_root, 2'b01});
        ge_root = rem_t >= trial;
        n_rem   = ge_root ? rem_t - trial : rem_t;
        n_root  = {r_root[ROOT_W-2:0], ge_root};
        gex     = r_rx >= r_dv;
        gez     = r_rz >= r_dv;
        gey     = r_ry >= r_dv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_sgx  <= i_job.dx[D_W-1];
                r_sgz  <= i_job.dz[D_W-1];
                r_end  <= i_job.frame_end;
                r_col  <= i_job.col;
                r_row  <= i_job.row;
                r_mx   <= ACC_W'(absx[MAG_W-1:0]);
                r_mz   <= ACC_W'(absz[MAG_W-1:0]);
                r_bx   <= SX_W'(i_gain);
                r_bz   <= SX_W'(i_gain);
                r_accx <= '0;
                r_accz <= '0;
                r_qx   <= '0;
                r_qz   <= '0;
                r_qy   <= Q_W'(ONE_Q14);
            end
            ST_MUL: begin
                if (w_last) begin
                    // Round the scaled slope to Q.16 and square it next.
                    r_sx   <= rndx[16 +: SX_W];
                    r_sz   <= rndz[16 +: SX_W];
                    r_mx   <= ACC_W'(rndx[16 +: SX_W]);
                    r_mz   <= ACC_W'(rndz[16 +: SX_W]);
                    r_bx   <= rndx[16 +: SX_W];
                    r_bz   <= rndz[16 +: SX_W];
                    r_accx <= '0;
                    r_accz <= '0;
                end else begin
                    r_accx <= n_accx;
                    r_accz <= n_accz;
                    r_mx   <= {r_mx[ACC_W-2:0], 1'b0};
                    r_mz   <= {r_mz[ACC_W-2:0], 1'b0};
                    r_bx   <= r_bx >> 1;
                    r_bz   <= r_bz >> 1;
                end
            end
            ST_SQR: begin
                if (w_last) begin
                    r_rad  <= RAD_W'(n_accx) + RAD_W'(n_accz) + (RAD_W'(1) << 32);
                    r_root <= '0;
                    r_rem  <= '0;
                end else begin
                    r_accx <= n_accx;
                    r_accz <= n_accz;
                    r_mx   <= {r_mx[ACC_W-2:0], 1'b0};
                    r_mz   <= {r_mz[ACC_W-2:0], 1'b0};
                    r_bx   <= r_bx >> 1;
                    r_bz   <= r_bz >> 1;
                end
            end
            ST_ROOT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                if (w_last) begin
                    // Numerators carry half the divisor so the quotient rounds.
                    r_dv <= DIV_W'({n_root, {(Q_W-1){1'b0}}});
                    r_rx <= DIV_W'({r_sx, {(Q_W-1){1'b0}}}) + DIV_W'(n_root[ROOT_W-1:1]);
                    r_rz <= DIV_W'({r_sz, {(Q_W-1){1'b0}}}) + DIV_W'(n_root[ROOT_W-1:1]);
                    r_ry <= (DIV_W'(1) << 30) + DIV_W'(n_root[ROOT_W-1:1]);
                    r_qx <= '0;
                    r_qz <= '0;
                    r_qy <= '0;
                end
            end
            ST_DIV: begin
                r_rx <= gex ? r_rx - r_dv : r_rx;
                r_rz <= gez ? r_rz - r_dv : r_rz;
                r_ry <= gey ? r_ry - r_dv : r_ry;
                r_qx <= {r_qx[Q_W-2:0], gex};
                r_qz <= {r_qz[Q_W-2:0], gez};
                r_qy <= {r_qy[Q_W-2:0], gey};
                r_dv <= r_dv >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_onx  <= signed_q(r_sgx, r_qx);
            r_onz  <= signed_q(r_sgz, r_qz);
            r_ony  <= NY_W'(clamp_q(r_qy));
            r_ocol <= r_col;
            r_orow <= r_row;
            r_oend <= r_end;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_normal_x     = $signed(r_onx);
    assign o_normal_y     = r_ony;
    assign o_normal_z     = $signed(r_onz);
    assign o_pixel_column = r_ocol;
    assign o_pixel_row    = r_orow;
    assign o_frame_end    = r_oend;

endmodule

// File: sv/heightmap_to_normal_map.sv
// Top level of the height map to normal map block: configuration registers and wiring.
// Depends on hnm_pkg, hnm_front, hnm_queue and hnm_back.
//
// Usage: height samples enter in raster order on the input channel (i_in_valid,
// o_in_stall); a transfer with i_cmd high is a flush tick that advances the window
// with height zero. After the last pixel of a frame, two rows of flush ticks drain
// the final normals. Each transfer from row two on yields one normal, two rows
// behind, on the output channel (o_out_valid, i_out_stall); rows zero and one yield
// nothing. Pixels in the two outer rings get (0, 16384, 0).
// Throughput: the front takes one transfer a cycle while the four-entry job queue
// has room. The normal unit works on one job at a time: a border normal passes
// from idle straight to done, while an interior normal runs the bit-serial unit
// through gain multiply, squaring, square root and division, in that order. A
// stalled receiver holds the output register; the unit then finishes its current
// job and waits, the queue fills, and o_in_stall rises.
// Reset clears the counters, the queue and the output register; configuration
// returns to 256 by 256 with gain 5461. Write configuration only while idle.
module heightmap_to_normal_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [hnm_pkg::GAIN_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [hnm_pkg::HS_W-1:0]          i_height_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [hnm_pkg::NRM_W-1:0]  o_normal_x,
    output logic [hnm_pkg::NY_W-1:0]          o_normal_y,
    output logic signed [hnm_pkg::NRM_W-1:0]  o_normal_z,
    output logic [hnm_pkg::POS_W-1:0]         o_pixel_column,
    output logic [hnm_pkg::POS_W-1:0]         o_pixel_row,
    output logic                              o_frame_end
);
    import hnm_pkg::*;

    t_dims              r_dims;
    logic [GAIN_W-1:0]  r_gain;

    logic               w_push, w_pop;
    t_job               w_job_in, w_job_out;
    logic [Q_LVL_W-1:0] w_level;

    // Register writes land at once; a write beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.width  <= DIM_W'(256);
            r_dims.height <= DIM_W'(256);
            r_gain        <= GAIN_W'(5461);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_dims.width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_dims.height <= i_cfg_data[DIM_W-1:0];
                CFG_SLOPE_GAIN:   r_gain        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front classifies each transfer and forms both stencil sums.
    hnm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dims          (r_dims),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_height_sample (i_height_sample),
        .i_q_level       (w_level),
        .o_push          (w_push),
        .o_job           (w_job_in)
    );

    hnm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_level (w_level)
    );

    // The back turns each job into a unit normal and holds it until transferred.
    hnm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_gain         (r_gain),
        .i_avail        (w_level != '0),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_frame_end    (o_frame_end)
    );

endmodule
